@@ rtl/core/scfc_pkg.sv @@
`default_nettype none
package scfc_pkg;

    // crc-16 modbus form
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int POS_W = 3;
    typedef logic [POS_W-1:0] pos_t;

    // byte positions within one reply frame
    localparam pos_t POS_FUNC    = 3'd0;
    localparam pos_t POS_LEN     = 3'd1;
    localparam pos_t POS_HUM_HI  = 3'd2;
    localparam pos_t POS_HUM_LO  = 3'd3;
    localparam pos_t POS_TEMP_HI = 3'd4;
    localparam pos_t POS_TEMP_LO = 3'd5;
    localparam pos_t POS_CRC_LO  = 3'd6;
    localparam pos_t POS_CRC_HI  = 3'd7;

    // one input beat as held in the input stage
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } in_beat_t;

    // one result beat
    typedef struct packed {
        logic [15:0] humidity;
        logic [15:0] temperature;
        logic [7:0]  func;
        logic [7:0]  length;
        logic [15:0] rx_crc;
        logic        crc_ok;
    } result_t;

    // one byte of the reflected crc, lsb first, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/scfc_in_stage.sv @@
`default_nettype none
module scfc_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             frame_start,
    input  wire logic             advance,
    output logic                  stage_valid,
    output scfc_pkg::in_beat_t    stage_beat
);
    import scfc_pkg::*;

    logic     stage_valid_reg;
    logic     stage_valid_next;
    in_beat_t beat_reg;

    // stage frees when empty or when its beat moves on
    assign in_ready = !stage_valid_reg || advance;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_ready)
            stage_valid_next = in_valid;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    // beat payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg.data  <= data_byte;
            beat_reg.start <= frame_start;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage_beat  = beat_reg;
endmodule
`default_nettype wire

@@ rtl/core/scfc_frame_core.sv @@
`default_nettype none
module scfc_frame_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             stage_valid,
    input  scfc_pkg::in_beat_t    stage_beat,
    output logic                  advance,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output scfc_pkg::result_t     res
);
    import scfc_pkg::*;

    pos_t        pos_reg,  pos_next;
    logic [15:0] crc_reg,  crc_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  len_reg,  len_next;
    logic [15:0] hum_reg,  hum_next;
    logic [15:0] temp_reg, temp_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    pos_t        pos;
    logic [15:0] crc_cur;
    logic [15:0] crc_upd;
    logic [15:0] rx_crc;
    logic        is_last;

    // frame start restarts position and crc
    assign pos     = stage_beat.start ? POS_FUNC : pos_reg;
    assign crc_cur = stage_beat.start ? CRC_INIT : crc_reg;
    assign crc_upd = (pos < POS_CRC_LO) ? crc16_byte(crc_cur, stage_beat.data) : crc_cur;
    assign is_last = (pos == POS_CRC_HI);
    assign rx_crc  = {stage_beat.data, crc_lo_reg};

    // only the last beat needs room downstream
    assign advance   = stage_valid && (!is_last || res_ready);
    assign res_valid = stage_valid && is_last;

    always_comb
    begin
        res.humidity    = hum_reg;
        res.temperature = temp_reg;
        res.func        = func_reg;
        res.length      = len_reg;
        res.rx_crc      = rx_crc;
        res.crc_ok      = (crc_upd == rx_crc);
    end

    // next frame state
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        func_next   = func_reg;
        len_next    = len_reg;
        hum_next    = hum_reg;
        temp_next   = temp_reg;
        crc_lo_next = crc_lo_reg;
        if (advance)
        begin
            case (pos)
                POS_FUNC:    func_next        = stage_beat.data;
                POS_LEN:     len_next         = stage_beat.data;
                POS_HUM_HI:  hum_next[15:8]   = stage_beat.data;
                POS_HUM_LO:  hum_next[7:0]    = stage_beat.data;
                POS_TEMP_HI: temp_next[15:8]  = stage_beat.data;
                POS_TEMP_LO: temp_next[7:0]   = stage_beat.data;
                POS_CRC_LO:  crc_lo_next      = stage_beat.data;
                default:     crc_lo_next      = crc_lo_reg;
            endcase
            if (is_last)
            begin
                pos_next = POS_FUNC;
                crc_next = CRC_INIT;
            end
            else
            begin
                pos_next = pos + 3'd1;
                crc_next = crc_upd;
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_FUNC;
            crc_reg    <= CRC_INIT;
            func_reg   <= 8'h00;
            len_reg    <= 8'h00;
            hum_reg    <= 16'h0000;
            temp_reg   <= 16'h0000;
            crc_lo_reg <= 8'h00;
        end
        else
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            func_reg   <= func_next;
            len_reg    <= len_next;
            hum_reg    <= hum_next;
            temp_reg   <= temp_next;
            crc_lo_reg <= crc_lo_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/scfc_result_reg.sv @@
`default_nettype none
module scfc_result_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_valid,
    output logic                  res_ready,
    input  scfc_pkg::result_t     res,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output scfc_pkg::result_t     out_res
);
    import scfc_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    // register takes a beat when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
            out_valid_next = res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            res_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
endmodule
`default_nettype wire

@@ rtl/core/sensor_frame_crc_checker.sv @@
// result path: input stage register, then output register; a full output register
// stalls a last byte; else one byte per cycle, set by the one-byte unrolled
// crc update between the input stage register and the frame state registers
// output register holds a waiting result while further bytes are taken
// reset: asynchronous active-low rst_n empties both stages, position 0, crc 0xffff
`default_nettype none
module sensor_frame_crc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      humidity_tenths,
    output logic [15:0]      temperature_tenths,
    output logic [7:0]       function_code,
    output logic [7:0]       data_length,
    output logic [15:0]      received_crc,
    output logic             crc_ok
);
    import scfc_pkg::*;

    logic     stage_valid;
    in_beat_t stage_beat;
    logic     advance;
    logic     res_valid;
    logic     res_ready;
    result_t  res;
    result_t  out_res;

    // input stage
    scfc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_beat  (stage_beat)
    );

    // frame tracking and crc
    scfc_frame_core u_frame_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_beat  (stage_beat),
        .advance     (advance),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // result register
    scfc_result_reg u_result_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign humidity_tenths    = out_res.humidity;
    assign temperature_tenths = out_res.temperature;
    assign function_code      = out_res.func;
    assign data_length        = out_res.length;
    assign received_crc       = out_res.rx_crc;
    assign crc_ok             = out_res.crc_ok;
endmodule
`default_nettype wire

@@ tb/tb_sensor_frame_crc_checker.sv @@
`default_nettype none

// tracks the reply frame byte by byte and holds the readings still owed by the block
class reply_frame_tracker;
    scfc_pkg::pos_t    next_pos;
    logic [15:0]       crc_acc;
    logic [7:0]        func_q;
    logic [7:0]        len_q;
    logic [15:0]       hum_q;
    logic [15:0]       temp_q;
    logic [7:0]        crc_lo_q;
    scfc_pkg::result_t pending_readings[$];
    int                errors;
    int                readings_checked;
    int                good_crc_count;
    int                bad_crc_count;
    int                dropped_frames;

    function new();
        next_pos         = scfc_pkg::POS_FUNC;
        crc_acc          = scfc_pkg::CRC_INIT;
        func_q           = 8'h00;
        len_q            = 8'h00;
        hum_q            = 16'h0000;
        temp_q           = 16'h0000;
        crc_lo_q         = 8'h00;
        errors           = 0;
        readings_checked = 0;
        good_crc_count   = 0;
        bad_crc_count    = 0;
        dropped_frames   = 0;
    endfunction

    // reflected crc-16, fed one data bit at a time, lsb first
    static function logic [15:0] crc_over_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ b[i])
                r = (r >> 1) ^ scfc_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // one accepted input beat
    function void take_byte(input logic [7:0] b, input logic start);
        scfc_pkg::pos_t    pos;
        scfc_pkg::result_t rd;
        if (start && next_pos != scfc_pkg::POS_FUNC)
            dropped_frames++;
        pos = start ? scfc_pkg::POS_FUNC : next_pos;
        if (start)
            crc_acc = scfc_pkg::CRC_INIT;
        if (pos <= scfc_pkg::POS_TEMP_LO)
            crc_acc = crc_over_byte(crc_acc, b);
        case (pos)
            scfc_pkg::POS_FUNC:    func_q = b;
            scfc_pkg::POS_LEN:     len_q = b;
            scfc_pkg::POS_HUM_HI:  hum_q[15:8] = b;
            scfc_pkg::POS_HUM_LO:  hum_q[7:0] = b;
            scfc_pkg::POS_TEMP_HI: temp_q[15:8] = b;
            scfc_pkg::POS_TEMP_LO: temp_q[7:0] = b;
            scfc_pkg::POS_CRC_LO:  crc_lo_q = b;
            default:
            begin
                rd.humidity    = hum_q;
                rd.temperature = temp_q;
                rd.func        = func_q;
                rd.length      = len_q;
                rd.rx_crc      = {b, crc_lo_q};
                rd.crc_ok      = (crc_acc == {b, crc_lo_q});
                pending_readings.push_back(rd);
            end
        endcase
        // full frame wraps back to the function code byte
        if (pos == scfc_pkg::POS_CRC_HI)
        begin
            next_pos = scfc_pkg::POS_FUNC;
            crc_acc  = scfc_pkg::CRC_INIT;
        end
        else
            next_pos = pos + 1'b1;
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 40)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // one accepted result beat against the oldest reading owed
    function void match_reading(input scfc_pkg::result_t got);
        scfc_pkg::result_t want;
        if (pending_readings.size() == 0)
        begin
            errors++;
            if (errors <= 40)
                $error("reading beat with none expected: hum 0x%0h temp 0x%0h crc 0x%0h",
                       got.humidity, got.temperature, got.rx_crc);
            return;
        end
        want = pending_readings.pop_front();
        compare_field("humidity_tenths", want.humidity, got.humidity);
        compare_field("temperature_tenths", want.temperature, got.temperature);
        compare_field("function_code", 16'(want.func), 16'(got.func));
        compare_field("data_length", 16'(want.length), 16'(got.length));
        compare_field("received_crc", want.rx_crc, got.rx_crc);
        compare_field("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
        readings_checked++;
        if (want.crc_ok)
            good_crc_count++;
        else
            bad_crc_count++;
    endfunction

    function int pending();
        return pending_readings.size();
    endfunction
endclass

module tb_sensor_frame_crc_checker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_BYTES = 1950;
    localparam int QUIET_TAIL  = 200;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 90;
    localparam int HOLD_AT     = 600;
    localparam int DRAIN_AT    = 1200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        frame_start;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] humidity_tenths;
    logic [15:0] temperature_tenths;
    logic [7:0]  function_code;
    logic [7:0]  data_length;
    logic [15:0] received_crc;
    logic        crc_ok;

    reply_frame_tracker tracker;
    int                 bytes_sent;
    int                 tx_calm_left;
    int                 idle_cycles;
    bit                 quiet_tail;
    bit                 rx_hold_req;

    sensor_frame_crc_checker dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .data_byte          (data_byte),
        .frame_start        (frame_start),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths),
        .function_code      (function_code),
        .data_length        (data_length),
        .received_crc       (received_crc),
        .crc_ok             (crc_ok)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("sensor_frame_crc_checker regression: fail");
            $finish;
        end
    end

    // result side: random stall bursts, calm stretches and one long hold-off
    initial
    begin
        int                stall_left;
        int                hold_left;
        int                calm_left;
        scfc_pkg::result_t seen;
        out_ready  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        calm_left  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                seen.humidity    = humidity_tenths;
                seen.temperature = temperature_tenths;
                seen.func        = function_code;
                seen.length      = data_length;
                seen.rx_crc      = received_crc;
                seen.crc_ok      = crc_ok;
                tracker.match_reading(seen);
            end
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (quiet_tail)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 3)
            begin
                calm_left = $urandom_range(20, 120);
                out_ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 10)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // offer one beat and hold it until taken
    task automatic send_beat(input logic [7:0] b, input logic s);
        in_valid    <= 1'b1;
        data_byte   <= b;
        frame_start <= s;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_byte(b, s);
        bytes_sent++;
    endtask

    // random idle burst on the input side, with calm stretches between
    task automatic sender_gap();
        int n;
        if (quiet_tail)
            return;
        if (tx_calm_left > 0)
        begin
            tx_calm_left--;
            return;
        end
        if ($urandom_range(0, 99) < 3)
        begin
            tx_calm_left = $urandom_range(20, 100);
            return;
        end
        if ($urandom_range(0, 99) < 8)
        begin
            n = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // six payload bytes followed by the crc, low byte first
    task automatic send_frame(input logic [7:0] body [6], input bit lead_start,
                              input bit good_crc);
        logic [15:0] crc;
        logic [15:0] sent_crc;
        crc = scfc_pkg::CRC_INIT;
        for (int i = 0; i < 6; i++)
            crc = scfc_pkg::crc16_byte(crc, body[i]);
        sent_crc = good_crc ? crc : crc ^ 16'($urandom_range(1, 65535));
        for (int i = 0; i < 6; i++)
        begin
            sender_gap();
            send_beat(body[i], lead_start && (i == 0));
        end
        sender_gap();
        send_beat(sent_crc[7:0], 1'b0);
        sender_gap();
        send_beat(sent_crc[15:8], 1'b0);
    endtask

    function automatic logic [7:0] pick_byte();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 8'h00;
        if (k == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // stop offering until every owed reading has come back
    task automatic drain_readings();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [7:0] body [6];
        int         kind;
        int         n;
        bit         next_start;
        bit         hold_done;
        bit         drain_done;
        tracker      = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        frame_start  = 1'b0;
        bytes_sent   = 0;
        tx_calm_left = 0;
        idle_cycles  = 0;
        quiet_tail   = 1'b0;
        rx_hold_req  = 1'b0;
        next_start   = 1'b1;
        hold_done    = 1'b0;
        drain_done   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero frame with a good crc
        body = '{default: 8'h00};
        send_frame(body, 1'b1, 1'b1);
        // all-ones frame straight after, no frame start, bad crc
        body = '{default: 8'hFF};
        send_frame(body, 1'b0, 1'b0);
        // partial frame cut short by a frame start
        send_beat(8'h03, 1'b1);
        send_beat(8'h04, 1'b0);
        body = '{8'h03, 8'h04, 8'h01, 8'hF4, 8'h00, 8'hFA};
        send_frame(body, 1'b1, 1'b1);

        // random part: mostly whole frames, some noise and truncated frames
        while (bytes_sent < TOTAL_BYTES)
        begin
            if (!hold_done && bytes_sent >= HOLD_AT)
            begin
                rx_hold_req = 1'b1;
                hold_done   = 1'b1;
            end
            if (!drain_done && bytes_sent >= DRAIN_AT)
            begin
                drain_readings();
                drain_done = 1'b1;
            end
            if (bytes_sent >= TOTAL_BYTES - QUIET_TAIL)
                quiet_tail = 1'b1;
            kind = $urandom_range(0, 99);
            foreach (body[i])
                body[i] = pick_byte();
            if (kind < 70)
            begin
                send_frame(body, next_start || ($urandom_range(0, 4) != 0),
                           $urandom_range(0, 4) != 0);
                next_start = 1'b0;
            end
            else if (kind < 85)
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    sender_gap();
                    send_beat(pick_byte(), $urandom_range(0, 7) == 0);
                end
                next_start = 1'b1;
            end
            else
            begin
                n = $urandom_range(1, 7);
                for (int i = 0; i < n; i++)
                begin
                    sender_gap();
                    send_beat(pick_byte(), i == 0);
                end
                next_start = 1'b1;
            end
        end

        drain_readings();
        repeat (8) @(posedge clk);

        $display("%0d bytes in, %0d readings checked (%0d good crc, %0d bad crc)",
                 bytes_sent, tracker.readings_checked, tracker.good_crc_count,
                 tracker.bad_crc_count);
        $display("%0d partial frames restarted, long output hold-off and full drain exercised",
                 tracker.dropped_frames);
        if (tracker.errors == 0)
            $display("sensor_frame_crc_checker regression: pass");
        else
            $display("sensor_frame_crc_checker regression: fail");
        $finish;
    end
endmodule

`default_nettype wire

@@ sensor_frame_crc_checker.f @@
rtl/core/scfc_pkg.sv
rtl/core/scfc_in_stage.sv
rtl/core/scfc_frame_core.sv
rtl/core/scfc_result_reg.sv
rtl/core/sensor_frame_crc_checker.sv
tb/tb_sensor_frame_crc_checker.sv
